// ===== rtl/tqg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqg_pkg
// Shared codes, state encodings and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package tqg_pkg;

  localparam int CFG_ADDR_W = 3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_REGION_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REGION_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TILE_WIDTH    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TILE_HEIGHT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TEX_U_LEFT    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TEX_U_RIGHT   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_TEX_V_BOTTOM  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_TEX_V_TOP     = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_CLIP_U = 5'b00100,
    S_CLIP_V = 5'b01000,
    S_EMIT   = 5'b10000
  } ctrl_state_t;

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_DIV  = 4'b0010,
    P_MUL  = 4'b0100,
    P_ADD  = 4'b1000
  } clip_phase_t;

  typedef struct packed {
    logic accept;      // take input transaction, set up walk position
    logic eval;        // place tile, update walk state
    logic clip_start;  // launch the clip unit
    logic clip_sel_v;  // clip unit works on v (else u)
    logic load_u;      // capture clipped u
    logic load_v;      // capture clipped v
    logic emit;        // move result to output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clip_u;
    logic clip_v;
    logic clip_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/tqg_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqg_clip
// Shared clip unit: restoring divide for the remaining fraction, one
// multiply, then interpolation from the near texture coordinate.
// ----------------------------------------------------------------------------
module tqg_clip import tqg_pkg::*; #(
  parameter int CW = 16,
  parameter int FB = 16,
  localparam int TW = FB + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [TW-1:0] near,
  input  logic [TW-1:0] far,
  input  logic [CW-1:0] rem,
  input  logic [CW-1:0] size,
  output logic          done,
  output logic [TW-1:0] result
);

  localparam int CNT_W = $clog2(FB + 1);
  localparam int PW    = TW + FB;

  clip_phase_t      phase;
  logic [CNT_W-1:0] cnt;
  logic [CW:0]      r;
  logic [FB-1:0]    q;
  logic [CW-1:0]    divisor;
  logic [TW-1:0]    near_q;
  logic [TW-1:0]    diff;
  logic             neg;
  logic [PW-1:0]    prod;

  logic [CW:0] r2;
  logic        ge;
  logic [CW:0] r_sub;

  // rem < size, so 2r stays within CW+1 bits
  assign r2    = {r[CW-1:0], 1'b0};
  assign ge    = r2 >= {1'b0, divisor};
  assign r_sub = r2 - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            phase <= P_DIV;
            cnt   <= CNT_W'(FB);
          end
        end
        P_DIV: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) phase <= P_MUL;
        end
        P_MUL: phase <= P_ADD;
        P_ADD: begin
          phase <= P_IDLE;
          done  <= 1'b1;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == P_IDLE && start) begin
      r       <= {1'b0, rem};
      q       <= '0;
      divisor <= size;
      near_q  <= near;
      neg     <= far < near;
      diff    <= (far >= near) ? far - near : near - far;
    end
    if (phase == P_DIV) begin
      r <= ge ? r_sub : r2;
      q <= {q[FB-2:0], ge};
    end
    if (phase == P_MUL) prod <= PW'(diff) * PW'(q);
    if (phase == P_ADD) begin
      result <= neg ? near_q - prod[PW-1:FB] : near_q + prod[PW-1:FB];
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> phase == P_IDLE)
    else $error("clip unit started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> phase == P_IDLE)
    else $error("clip done outside idle phase");

endmodule

// ===== rtl/tqg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqg_dp
// Datapath: config registers, walk position, tile placement, clip unit and
// output register.
// ----------------------------------------------------------------------------
module tqg_dp import tqg_pkg::*; #(
  parameter int CW = 16,
  parameter int FB = 16,
  localparam int TW       = FB + 1,
  localparam int CFG_W    = (CW > TW) ? CW : TW,
  localparam int OUT_BITS = 4 * CW + 4 * TW,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  restart,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  localparam logic [TW-1:0] TEX_ONE = TW'(65536);

  logic [CW-1:0] region_width, region_height, tile_width, tile_height;
  logic [TW-1:0] tex_u_left, tex_u_right, tex_v_bottom, tex_v_top;

  logic [CW-1:0] next_x, next_y;
  logic          walk_done;

  logic [CW-1:0] wx;
  logic [CW:0]   wy;
  logic          wskip;

  logic [CW-1:0] res_xl, res_xr, res_yb, res_yt;
  logic [TW-1:0] res_ul, res_ur, res_vb, res_vt;
  logic          res_last, res_none;

  logic          empty, skip0, row_wrap;
  logic [CW-1:0] x0, y0;
  logic [CW:0]   y_wrap, xr_sum, yt_sum;
  logic          tile_ok, clip_u, clip_v, row_end, col_end;

  logic [TW-1:0] clip_near, clip_far, clip_result;
  logic [CW-1:0] clip_rem, clip_size;
  logic          clip_done;

  // ---- config ----
  always_ff @(posedge clk) begin
    if (rst) begin
      region_width  <= '0;
      region_height <= '0;
      tile_width    <= '0;
      tile_height   <= '0;
      tex_u_left    <= '0;
      tex_u_right   <= TEX_ONE;
      tex_v_bottom  <= '0;
      tex_v_top     <= TEX_ONE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_REGION_WIDTH:  region_width  <= cfg_data[CW-1:0];
        REG_REGION_HEIGHT: region_height <= cfg_data[CW-1:0];
        REG_TILE_WIDTH:    tile_width    <= cfg_data[CW-1:0];
        REG_TILE_HEIGHT:   tile_height   <= cfg_data[CW-1:0];
        REG_TEX_U_LEFT:    tex_u_left    <= cfg_data[TW-1:0];
        REG_TEX_U_RIGHT:   tex_u_right   <= cfg_data[TW-1:0];
        REG_TEX_V_BOTTOM:  tex_v_bottom  <= cfg_data[TW-1:0];
        REG_TEX_V_TOP:     tex_v_top     <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // ---- walk set-up on accept ----
  always_comb begin
    empty    = (region_width == '0) || (region_height == '0) ||
               (tile_width == '0) || (tile_height == '0);
    x0       = restart ? '0 : next_x;
    y0       = restart ? '0 : next_y;
    skip0    = empty || (!restart && walk_done);
    row_wrap = x0 >= region_width;
    y_wrap   = {1'b0, y0} + {1'b0, tile_height};
  end

  // ---- tile placement ----
  always_comb begin
    tile_ok = !wskip && (wy < {1'b0, region_height});
    xr_sum  = {1'b0, wx} + {1'b0, tile_width};
    yt_sum  = wy + {1'b0, tile_height};
    clip_u  = tile_ok && (xr_sum > {1'b0, region_width});
    clip_v  = tile_ok && (yt_sum > {1'b0, region_height});
    row_end = xr_sum >= {1'b0, region_width};
    col_end = yt_sum >= {1'b0, region_height};
  end

  // ---- clip unit ----
  always_comb begin
    if (cmd.clip_sel_v) begin
      clip_near = tex_v_bottom;
      clip_far  = tex_v_top;
      clip_rem  = region_height - wy[CW-1:0];
      clip_size = tile_height;
    end else begin
      clip_near = tex_u_left;
      clip_far  = tex_u_right;
      clip_rem  = region_width - wx;
      clip_size = tile_width;
    end
  end

  tqg_clip #(.CW(CW), .FB(FB)) u_clip (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.clip_start),
    .near   (clip_near),
    .far    (clip_far),
    .rem    (clip_rem),
    .size   (clip_size),
    .done   (clip_done),
    .result (clip_result)
  );

  always_comb begin
    stat.clip_u    = clip_u;
    stat.clip_v    = clip_v;
    stat.clip_done = clip_done;
    stat.out_free  = !m_tvalid || m_tready;
  end

  // ---- walk state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      next_x    <= '0;
      next_y    <= '0;
      walk_done <= 1'b0;
    end else if (cmd.accept && restart) begin
      next_x    <= '0;
      next_y    <= '0;
      walk_done <= 1'b0;
    end else if (cmd.eval && !wskip) begin
      if (!tile_ok) begin
        walk_done <= 1'b1;
      end else if (row_end) begin
        next_x <= '0;
        if (col_end) begin
          walk_done <= 1'b1;
          next_y    <= '0;
        end else begin
          next_y <= yt_sum[CW-1:0];
        end
      end else begin
        next_x <= xr_sum[CW-1:0];
        next_y <= wy[CW-1:0];
      end
    end
  end

  // ---- working values and result ----
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wx    <= row_wrap ? '0 : x0;
      wy    <= row_wrap ? y_wrap : {1'b0, y0};
      wskip <= skip0;
    end
    if (cmd.eval) begin
      if (tile_ok) begin
        res_xl   <= wx;
        res_xr   <= clip_u ? region_width : xr_sum[CW-1:0];
        res_yb   <= wy[CW-1:0];
        res_yt   <= clip_v ? region_height : yt_sum[CW-1:0];
        res_ul   <= tex_u_left;
        res_ur   <= tex_u_right;
        res_vb   <= tex_v_bottom;
        res_vt   <= tex_v_top;
        res_last <= row_end && col_end;
        res_none <= 1'b0;
      end else begin
        res_xl   <= '0;
        res_xr   <= '0;
        res_yb   <= '0;
        res_yt   <= '0;
        res_ul   <= '0;
        res_ur   <= '0;
        res_vb   <= '0;
        res_vt   <= '0;
        res_last <= 1'b0;
        res_none <= 1'b1;
      end
    end
    if (cmd.load_u) res_ur <= clip_result;
    if (cmd.load_v) res_vt <= clip_result;
    if (cmd.emit) begin
      m_tdata <= OUT_W'({res_vt, res_vb, res_ur, res_ul,
                         res_yt, res_yb, res_xr, res_xl});
      m_tlast <= res_last;
      m_tuser <= res_none;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_quad_ordered: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      (m_tdata[CW-1:0] < m_tdata[2*CW-1:CW]) &&
      (m_tdata[3*CW-1:2*CW] < m_tdata[4*CW-1:3*CW]))
    else $error("quad edges out of order");

  a_no_tile_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == '0) && !m_tlast)
    else $error("no_tile result carries data");

  a_load_v_needed: assert property (@(posedge clk) disable iff (rst)
    cmd.load_v |-> clip_v)
    else $error("v clip loaded for unclipped tile");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    walk_done && !(cmd.accept && restart) |=> walk_done)
    else $error("walk_done cleared without restart");

endmodule

// ===== rtl/tqg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqg_ctrl
// Controller: sequences accept, placement, u/v clip and output load.
// ----------------------------------------------------------------------------
module tqg_ctrl import tqg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.clip_u) begin
          cmd.clip_start = 1'b1;
          state_next     = S_CLIP_U;
        end else if (stat.clip_v) begin
          cmd.clip_start = 1'b1;
          cmd.clip_sel_v = 1'b1;
          state_next     = S_CLIP_V;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_CLIP_U: begin
        if (stat.clip_done) begin
          cmd.load_u = 1'b1;
          if (stat.clip_v) begin
            cmd.clip_start = 1'b1;
            cmd.clip_sel_v = 1'b1;
            state_next     = S_CLIP_V;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_CLIP_V: begin
        cmd.clip_sel_v = 1'b1;
        if (stat.clip_done) begin
          cmd.load_v = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/tile_quad_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_quad_generator
// Walks a region with copies of one tile, one clipped quad per transaction.
// ----------------------------------------------------------------------------
// Sequence: the input transaction is accepted (S_IDLE), the tile is placed
//   (S_EVAL) and the quad is loaded into the output register once it is free
//   (S_EMIT); each clipped edge (right column, top row) first passes through
//   the shared clip unit (divide, multiply, add). One transaction in flight:
//   no new request is taken until the last quad is loaded for output.
// Reset: rst synchronous, active high; registers to defaults, walk restarts.
// ----------------------------------------------------------------------------
module tile_quad_generator import tqg_pkg::*; #(
  parameter int COORD_WIDTH   = 16,
  parameter int TEX_FRAC_BITS = 16,
  localparam int TW       = TEX_FRAC_BITS + 1,
  localparam int CFG_W    = (COORD_WIDTH > TW) ? COORD_WIDTH : TW,
  localparam int OUT_BITS = 4 * COORD_WIDTH + 4 * TW,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] restart, rest zero
  // quad stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // quad_x_left, quad_x_right,
                                           // quad_y_bottom, quad_y_top,
                                           // out_u_left, out_u_right,
                                           // out_v_bottom, out_v_top, zero pad
  output logic                  m_tlast,   // last_tile
  output logic                  m_tuser,   // no_tile
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The user must change registers only between items; the block itself does not enforce it and always takes writes.
  assign cfg_ready = 1'b1;

  // Controller: one item at a time, clip unit reused for u then v.
  tqg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: registers, walk position, clip arithmetic and the output
  // register that decouples the quad stream from the walk.
  tqg_dp #(.CW(COORD_WIDTH), .FB(TEX_FRAC_BITS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .restart  (s_tdata[0]),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
